>>> src/nvr_pkg.sv
`timescale 1ns / 1ps

package nvr_pkg;

   // Field widths of the command and result beats.
   localparam int IDX_W   = 8;
   localparam int VOXEL_W = 16;
   localparam int CHAN_W  = 1;

   // Configuration register widths.
   localparam int SIZE_W  = 6;
   localparam int RATIO_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Mapping arithmetic widths: the Q16.16 product, the rounded integer index and the clamp bound.
   localparam int PROD_W  = IDX_W + RATIO_W;
   localparam int MAP_W   = PROD_W + 1 - 16;
   localparam int BOUND_W = 11;

   // Default address split of the voxel store.
   localparam int X_BITS_DEFAULT       = 5;
   localparam int Y_BITS_DEFAULT       = 5;
   localparam int Z_BITS_DEFAULT       = 5;
   localparam int CHANNEL_BITS_DEFAULT = 1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_SIZE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_SIZE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_SIZE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND      = 3'd6;

   // Register reset values.
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 6'd32;
   localparam logic [RATIO_W-1:0] RATIO_RESET = 24'd65536;

   // Largest positive integer value in Q12.4 (2047.0).
   localparam logic [VOXEL_W-1:0] ROUND_SAT = 16'h7FF0;

   // Rounds a Q12.4 value to an integer, halves away from zero, saturating at 2047.0.
   function automatic logic [VOXEL_W-1:0] round_q4(input logic [VOXEL_W-1:0] raw);
      logic [VOXEL_W:0]   mag;
      logic [VOXEL_W:0]   rnd;
      logic [VOXEL_W-1:0] res;
      if (!raw[VOXEL_W-1]) begin
         rnd = ({1'b0, raw} + 17'd8) & ~17'h0000F;
         res = rnd[VOXEL_W-1] ? ROUND_SAT : rnd[VOXEL_W-1:0];
      end else begin
         mag = {1'b0, ~raw} + 17'd1;
         rnd = (mag + 17'd8) & ~17'h0000F;
         res = 16'(17'd0 - rnd);
      end
      return res;
   endfunction

endpackage

>>> src/nvr_ram.sv
`timescale 1ns / 1ps

module nvr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port: one address per cycle, with an optional write and a registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/nvr_axis_map.sv
`timescale 1ns / 1ps

module nvr_axis_map #(
   parameter int BITS = nvr_pkg::X_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic [nvr_pkg::IDX_W-1:0]   idx,
   input  logic [nvr_pkg::RATIO_W-1:0] ratio,
   input  logic [nvr_pkg::SIZE_W-1:0]  size,
   output logic [BITS-1:0]             mapped
);

   import nvr_pkg::*;

   localparam logic [BOUND_W-1:0] LIM = BOUND_W'(1 << BITS);

   logic [PROD_W-1:0]  prod_ff;
   logic [MAP_W-1:0]   near;
   logic [SIZE_W-1:0]  size_nz;
   logic [BOUND_W-1:0] size_cl;
   logic [BOUND_W-1:0] bound;

   // Scale the output index by the ratio; the product is registered.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(idx) * PROD_W'(ratio);
   end

   // Round to the nearest source index and clamp to the usable source extent.
   always_comb begin
      near    = MAP_W'(({1'b0, prod_ff} + (PROD_W + 1)'(32768)) >> 16);
      size_nz = (size == '0) ? SIZE_W'(1) : size;
      size_cl = (BOUND_W'(size_nz) > LIM) ? LIM : BOUND_W'(size_nz);
      bound   = size_cl - BOUND_W'(1);
      mapped  = (near > MAP_W'(bound)) ? BITS'(bound) : BITS'(near);
   end

endmodule

>>> src/nearest_volume_resampler_core.sv
`timescale 1ns / 1ps

// Nearest-neighbor volume resampler: voxel store plus per-axis index mapping.
// A fetch goes through stage 1, the stage 2 store read and the result register.
// Throughput: one command per cycle; busy stays low, as the single store port is
// used once per command at a fixed pipeline stage, which also keeps accesses in order.
// Reset restores the registers to their defaults; the voxel store is not cleared.
// The receiver cannot stall, so a result is shown for exactly its strobe cycle.
module nearest_volume_resampler_core #(
   parameter int X_BITS       = nvr_pkg::X_BITS_DEFAULT,
   parameter int Y_BITS       = nvr_pkg::Y_BITS_DEFAULT,
   parameter int Z_BITS       = nvr_pkg::Z_BITS_DEFAULT,
   parameter int CHANNEL_BITS = nvr_pkg::CHANNEL_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Command channel.
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_command,
   input  logic [nvr_pkg::IDX_W-1:0]      req_coord_x,
   input  logic [nvr_pkg::IDX_W-1:0]      req_coord_y,
   input  logic [nvr_pkg::IDX_W-1:0]      req_coord_z,
   input  logic [nvr_pkg::CHAN_W-1:0]     req_channel,
   input  logic signed [nvr_pkg::VOXEL_W-1:0] req_voxel_in,
   // Result channel.
   output logic                           rsp_strobe,
   output logic signed [nvr_pkg::VOXEL_W-1:0] rsp_voxel_out,
   // Configuration channel.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nvr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nvr_pkg::CSR_DATA_W-1:0] csr_data
);

   import nvr_pkg::*;

   localparam int XYZ_BITS = X_BITS + Y_BITS + Z_BITS;
   localparam int ADDR_W   = XYZ_BITS + CHANNEL_BITS;
   localparam int AW1      = ADDR_W + 1;

   // Configuration registers.
   logic [SIZE_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [RATIO_W-1:0] ratio_x_ff, ratio_y_ff, ratio_z_ff;
   logic               round_ff;

   // Stage 1: command beat held while the products settle.
   logic               s1_valid_ff;
   logic               s1_fetch_ff;
   logic               s1_wr_ok_ff;
   logic               s1_chan_ok_ff;
   logic [CHAN_W-1:0]  s1_chan_ff;
   logic [IDX_W-1:0]   s1_x_ff, s1_y_ff, s1_z_ff;
   logic [VOXEL_W-1:0] s1_voxel_ff;

   // Stage 2: store read in flight.
   logic               s2_valid_ff;
   logic               s2_chan_ok_ff;
   logic               s2_round_ff;

   // Result register.
   logic               rsp_strobe_ff;
   logic               rsp_round_ff;
   logic [VOXEL_W-1:0] rsp_voxel_ff;

   logic               accept;
   logic               csr_write;
   logic               chan_ok;
   logic               coord_ok;
   logic [X_BITS-1:0]  map_x;
   logic [Y_BITS-1:0]  map_y;
   logic [Z_BITS-1:0]  map_z;
   logic [AW1-1:0]     fetch_addr;
   logic [AW1-1:0]     write_addr;
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_we;
   logic [VOXEL_W-1:0] mem_rdata;
   logic [VOXEL_W-1:0] voxel_next;

   // Register beats wait until no command is offered or in flight.
   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign csr_ready = !(start || s1_valid_ff || s2_valid_ff || rsp_strobe_ff);
   assign csr_write = csr_valid && csr_ready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff  <= SIZE_RESET;
         size_y_ff  <= SIZE_RESET;
         size_z_ff  <= SIZE_RESET;
         ratio_x_ff <= RATIO_RESET;
         ratio_y_ff <= RATIO_RESET;
         ratio_z_ff <= RATIO_RESET;
         round_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SRC_SIZE_X: size_x_ff  <= csr_data[SIZE_W-1:0];
            CSR_SRC_SIZE_Y: size_y_ff  <= csr_data[SIZE_W-1:0];
            CSR_SRC_SIZE_Z: size_z_ff  <= csr_data[SIZE_W-1:0];
            CSR_RATIO_X:    ratio_x_ff <= csr_data[RATIO_W-1:0];
            CSR_RATIO_Y:    ratio_y_ff <= csr_data[RATIO_W-1:0];
            CSR_RATIO_Z:    ratio_z_ff <= csr_data[RATIO_W-1:0];
            CSR_ROUND:      round_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // A channel or a write coordinate that does not fit its address field is out of range.
   assign chan_ok  = (CHANNEL_BITS > 0) || (req_channel == '0);
   assign coord_ok = ((req_coord_x >> X_BITS) == '0) && ((req_coord_y >> Y_BITS) == '0)
                     && ((req_coord_z >> Z_BITS) == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_fetch_ff   <= req_command;
      s1_wr_ok_ff   <= chan_ok && coord_ok;
      s1_chan_ok_ff <= chan_ok;
      s1_chan_ff    <= req_channel;
      s1_x_ff       <= req_coord_x;
      s1_y_ff       <= req_coord_y;
      s1_z_ff       <= req_coord_z;
      s1_voxel_ff   <= req_voxel_in;
   end

   // Per-axis index mapping, one multiplier each.
   nvr_axis_map #(.BITS(X_BITS)) u_map_x (
      .clock  (clock),
      .idx    (req_coord_x),
      .ratio  (ratio_x_ff),
      .size   (size_x_ff),
      .mapped (map_x)
   );

   nvr_axis_map #(.BITS(Y_BITS)) u_map_y (
      .clock  (clock),
      .idx    (req_coord_y),
      .ratio  (ratio_y_ff),
      .size   (size_y_ff),
      .mapped (map_y)
   );

   nvr_axis_map #(.BITS(Z_BITS)) u_map_z (
      .clock  (clock),
      .idx    (req_coord_z),
      .ratio  (ratio_z_ff),
      .size   (size_z_ff),
      .mapped (map_z)
   );

   // Store address: channel, z, y, x from high bits to low.
   always_comb begin
      fetch_addr = AW1'(map_x) | (AW1'(map_y) << X_BITS)
                   | (AW1'(map_z) << (X_BITS + Y_BITS))
                   | (AW1'(s1_chan_ff) << XYZ_BITS);
      write_addr = AW1'(s1_x_ff) | (AW1'(s1_y_ff) << X_BITS)
                   | (AW1'(s1_z_ff) << (X_BITS + Y_BITS))
                   | (AW1'(s1_chan_ff) << XYZ_BITS);
      mem_addr   = s1_fetch_ff ? fetch_addr[ADDR_W-1:0] : write_addr[ADDR_W-1:0];
      mem_we     = s1_valid_ff && !s1_fetch_ff && s1_wr_ok_ff;
   end

   nvr_ram #(
      .WIDTH (VOXEL_W),
      .DEPTH (1 << ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (s1_voxel_ff),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_fetch_ff;
      end
      s2_chan_ok_ff <= s1_chan_ok_ff;
      s2_round_ff   <= round_ff;
   end

   // Optional label rounding; an out-of-range channel answers zero.
   always_comb begin
      if (!s2_chan_ok_ff) begin
         voxel_next = '0;
      end else if (s2_round_ff) begin
         voxel_next = round_q4(mem_rdata);
      end else begin
         voxel_next = mem_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s2_valid_ff;
      end
      rsp_round_ff <= s2_round_ff && s2_chan_ok_ff;
      rsp_voxel_ff <= voxel_next;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_voxel_out = rsp_voxel_ff;

   // Every fetch beat yields its result beat.
   a_fetch_answered: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command) |-> ##3 rsp_strobe)
      else $error("fetch beat produced no result");

   // A result beat always traces back to a fetch beat.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept && req_command, 3))
      else $error("result beat without a fetch");

   // Rounded results are whole numbers in Q12.4.
   a_round_whole: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_round_ff) |-> (rsp_voxel_out[3:0] == 4'd0))
      else $error("rounded voxel has a fraction");

endmodule
